>>> hdl/r3329_pkg.sv
package r3329_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LANES   = 6;
	localparam int unsigned PAIRS   = LANES / 2;
	localparam int unsigned RES_W   = 12;
	localparam int unsigned MU_W    = 21;
	// remainder before the conditional subtract stays below 2*Q
	localparam int unsigned REM_W   = 13;
	localparam int unsigned PROD_W  = 2 * RES_W;
	localparam int unsigned PAIR_W  = PROD_W + 1;
	localparam int unsigned SUM_W   = PROD_W + 3;
	localparam int unsigned STAGES  = 9;

	localparam logic [RES_W-1:0] MOD_Q      = 12'd3329;
	localparam logic [MU_W-1:0]  BARRETT_MU = 21'd1290167;

	typedef logic [RES_W-1:0] res_t;
	typedef logic [WORD_W-1:0] word_t;

	// 2^(32*i) mod q for each word position
	localparam res_t WORD_WEIGHT [LANES] = '{
		12'd1, 12'd1353, 12'd2988, 12'd1358, 12'd3095, 12'd2982
	};

endpackage

>>> hdl/reduce_192bit_mod_3329.sv
// Reduces a 192-bit value, given as six little-endian 32-bit words, modulo
// 3329. Six lanes each take one word through a Barrett reduction and a
// multiply by that word's weight 2^(32i) mod 3329; a two-level adder tree
// sums the lanes and a last Barrett reduction gives the residue. One 192-bit
// value (all six words) is taken every cycle that word_ready is high; the
// pipeline has three Barrett stages per reduction, the weight multiply and
// two adder stages. When res_ready is low with a result waiting, the whole
// pipeline holds and word_ready drops.
module reduce_192bit_mod_3329 (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     word_valid,
	output logic                     word_ready,
	input  logic [31:0]              word0,
	input  logic [31:0]              word1,
	input  logic [31:0]              word2,
	input  logic [31:0]              word3,
	input  logic [31:0]              word4,
	input  logic [31:0]              word5,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [11:0]              residue
);

	logic                                en;
	logic [r3329_pkg::STAGES-1:0]        vld_q;
	r3329_pkg::word_t                    words [r3329_pkg::LANES];
	logic [r3329_pkg::PROD_W-1:0]        prods [r3329_pkg::LANES];
	logic [r3329_pkg::SUM_W-1:0]         sum;
	r3329_pkg::res_t                     res;

	// pipeline moves unless the result at the end is stuck
	assign en         = !vld_q[r3329_pkg::STAGES-1] || res_ready;
	assign word_ready = en;

	assign words[0] = word0;
	assign words[1] = word1;
	assign words[2] = word2;
	assign words[3] = word3;
	assign words[4] = word4;
	assign words[5] = word5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[r3329_pkg::STAGES-2:0], word_valid};
		end
	end

	for (genvar i = 0; i < r3329_pkg::LANES; i++) begin : g_lane
		r3329_lane u_lane (
			.clk    (clk),
			.en     (en),
			.w      (words[i]),
			.weight (r3329_pkg::WORD_WEIGHT[i]),
			.prod   (prods[i])
		);
	end

	r3329_merge u_merge (
		.clk  (clk),
		.en   (en),
		.prod (prods),
		.sum  (sum)
	);

	r3329_barrett u_final (
		.clk (clk),
		.en  (en),
		.v   (r3329_pkg::WORD_W'(sum)),
		.rem (res)
	);

	assign res_valid = vld_q[r3329_pkg::STAGES-1];
	assign residue   = res;

	a_res_range : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (residue < r3329_pkg::MOD_Q))
		else $error("residue out of range");

	a_hold_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> ($stable(vld_q) && !$past(word_ready)))
		else $error("pipeline moved while output stalled");

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_ready) |=> vld_q[0])
		else $error("accepted word lost at entry");

endmodule

>>> hdl/r3329_barrett.sv
module r3329_barrett (
	input  logic              clk,
	input  logic              en,
	input  r3329_pkg::word_t  v,
	output r3329_pkg::res_t   rem
);

	logic [r3329_pkg::WORD_W+r3329_pkg::MU_W-1:0]  mu_prod;
	logic [r3329_pkg::MU_W+r3329_pkg::RES_W-1:0]   q_prod;
	logic [r3329_pkg::MU_W-1:0]                    quot_s1;
	logic [r3329_pkg::REM_W-1:0]                   vlo_s1;
	logic [r3329_pkg::REM_W-1:0]                   vlo_s2;
	logic [r3329_pkg::REM_W-1:0]                   qq_s2;
	logic [r3329_pkg::REM_W-1:0]                   diff;
	logic [r3329_pkg::REM_W-1:0]                   q_ext;
	r3329_pkg::res_t                               rem_s3;

	assign mu_prod = v * r3329_pkg::BARRETT_MU;
	assign q_prod  = quot_s1 * r3329_pkg::MOD_Q;
	assign q_ext   = {1'b0, r3329_pkg::MOD_Q};
	// only the low bits matter: the true remainder fits REM_W
	assign diff    = vlo_s2 - qq_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s1 <= mu_prod[r3329_pkg::WORD_W +: r3329_pkg::MU_W];
			vlo_s1  <= v[r3329_pkg::REM_W-1:0];
			qq_s2   <= q_prod[r3329_pkg::REM_W-1:0];
			vlo_s2  <= vlo_s1;
			if (diff >= q_ext) begin
				rem_s3 <= r3329_pkg::RES_W'(diff - q_ext);
			end else begin
				rem_s3 <= diff[r3329_pkg::RES_W-1:0];
			end
		end
	end

	assign rem = rem_s3;

endmodule

>>> hdl/r3329_lane.sv
module r3329_lane (
	input  logic                                clk,
	input  logic                                en,
	input  r3329_pkg::word_t                    w,
	input  r3329_pkg::res_t                     weight,
	output logic [r3329_pkg::PROD_W-1:0]        prod
);

	r3329_pkg::res_t                     red;
	logic [r3329_pkg::PROD_W-1:0]        prod_s4;

	r3329_barrett u_barrett (
		.clk (clk),
		.en  (en),
		.v   (w),
		.rem (red)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= red * weight;
		end
	end

	assign prod = prod_s4;

endmodule

>>> hdl/r3329_merge.sv
module r3329_merge (
	input  logic                                clk,
	input  logic                                en,
	input  logic [r3329_pkg::PROD_W-1:0]        prod [r3329_pkg::LANES],
	output logic [r3329_pkg::SUM_W-1:0]         sum
);

	logic [r3329_pkg::PAIR_W-1:0] pair_s5 [r3329_pkg::PAIRS];
	logic [r3329_pkg::SUM_W-1:0]  sum_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < r3329_pkg::PAIRS; i++) begin
				pair_s5[i] <= r3329_pkg::PAIR_W'(prod[2*i])
					+ r3329_pkg::PAIR_W'(prod[2*i+1]);
			end
			sum_s6 <= r3329_pkg::SUM_W'(pair_s5[0]) + r3329_pkg::SUM_W'(pair_s5[1])
				+ r3329_pkg::SUM_W'(pair_s5[2]);
		end
	end

	assign sum = sum_s6;

endmodule
